@@ rtl/gspd_pkg.sv @@
// Package for the gain-scheduled PD controller: defaults, register codes and shared types.
package gspd_pkg;

	localparam int DEF_ERROR_WIDTH    = 16;
	localparam int DEF_GAIN_FRAC_BITS = 12;
	localparam int QUEUE_DEPTH        = 4;

	localparam int GAIN_W   = 16;
	localparam int THRESH_W = 17;
	localparam int LIMIT_W  = 15;
	localparam int SPEED_W  = 8;
	localparam int DRIVE_W  = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 17;

	localparam logic [SPEED_W-1:0] SPEED_RESTART = SPEED_W'(55);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_FAST   = 8'd0,
		REG_KD_FAST   = 8'd1,
		REG_KP_SLOW   = 8'd2,
		REG_KD_SLOW   = 8'd3,
		REG_KI_GAIN   = 8'd4,
		REG_BIAS      = 8'd5,
		REG_THRESHOLD = 8'd6,
		REG_OUT_LIMIT = 8'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   kp_fast;
		logic [GAIN_W-1:0]   kd_fast;
		logic [GAIN_W-1:0]   kp_slow;
		logic [GAIN_W-1:0]   kd_slow;
		logic [GAIN_W-1:0]   ki_gain;
		logic [GAIN_W-1:0]   bias_term;
		logic [THRESH_W-1:0] change_threshold;
		logic [LIMIT_W-1:0]  out_limit;
	} gspd_cfg_t;

endpackage

@@ rtl/gspd_cfg.sv @@
// Configuration register file of the controller.
module gspd_cfg
	import gspd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output gspd_cfg_t             cfg
);

	gspd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// The limit sits in the lowest bits; every other register resets to zero.
			cfg_q <= {{($bits(gspd_cfg_t) - LIMIT_W){1'b0}}, LIMIT_RESET};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KP_FAST:   cfg_q.kp_fast <= wr_data[GAIN_W-1:0];
				REG_KD_FAST:   cfg_q.kd_fast <= wr_data[GAIN_W-1:0];
				REG_KP_SLOW:   cfg_q.kp_slow <= wr_data[GAIN_W-1:0];
				REG_KD_SLOW:   cfg_q.kd_slow <= wr_data[GAIN_W-1:0];
				REG_KI_GAIN:   cfg_q.ki_gain <= wr_data[GAIN_W-1:0];
				REG_BIAS:      cfg_q.bias_term <= wr_data[GAIN_W-1:0];
				REG_THRESHOLD: cfg_q.change_threshold <= wr_data[THRESH_W-1:0];
				REG_OUT_LIMIT: cfg_q.out_limit <= wr_data[LIMIT_W-1:0];
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/gspd_front.sv @@
// Front end: forms the change, picks the gain set and updates the speed counter.
module gspd_front
	import gspd_pkg::*;
#(
	parameter int ERROR_WIDTH = DEF_ERROR_WIDTH,
	parameter int ENT_W       = 2 * DEF_ERROR_WIDTH + 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [ERROR_WIDTH-1:0] error_sample,
	input  logic [SPEED_W-1:0]     speed_count_in,
	input  gspd_cfg_t              cfg,
	output logic [ENT_W-1:0]       entry
);

	localparam int CHG_W = ERROR_WIDTH + 1;
	localparam int CMP_W = (CHG_W > THRESH_W) ? CHG_W : THRESH_W;

	logic signed [ERROR_WIDTH-1:0] last_error_q;
	logic signed [CHG_W-1:0]       last_change_q;
	logic signed [ERROR_WIDTH-1:0] err;
	logic signed [CHG_W-1:0]       change;
	logic [CHG_W-1:0]              mag_chg;
	logic [CHG_W-1:0]              mag_last;
	logic                          fast;
	logic [SPEED_W-1:0]            speed_new;

	assign err    = $signed(error_sample);
	assign change = CHG_W'(err) - CHG_W'(last_error_q);

	// The magnitude of the most negative change still fits as an unsigned value.
	assign mag_chg  = change[CHG_W-1] ? CHG_W'(-change) : CHG_W'(change);
	assign mag_last = last_change_q[CHG_W-1] ? CHG_W'(-last_change_q) : CHG_W'(last_change_q);

	assign fast = CMP_W'(change) > CMP_W'($signed(cfg.change_threshold));

	assign speed_new = (mag_chg < mag_last) ? speed_count_in + SPEED_W'(1) : SPEED_RESTART;

	assign entry = {speed_new, fast, change, err};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q  <= '0;
			last_change_q <= '0;
		end else if (accept) begin
			last_error_q  <= err;
			last_change_q <= change;
		end
	end

endmodule

@@ rtl/gspd_fifo.sv @@
// Short register queue between the front end and the arithmetic back end.
module gspd_fifo
	import gspd_pkg::*;
#(
	parameter int WIDTH = 2 * DEF_ERROR_WIDTH + 10,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/gspd_back.sv @@
// Back end: multiply, sum, truncate toward zero and saturate, with the output register.
module gspd_back
	import gspd_pkg::*;
#(
	parameter int ERROR_WIDTH    = DEF_ERROR_WIDTH,
	parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
	parameter int ENT_W          = 2 * DEF_ERROR_WIDTH + 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ENT_W-1:0]   entry,
	input  logic               entry_valid,
	output logic               entry_pop,
	input  gspd_cfg_t          cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DRIVE_W-1:0] drive_value,
	output logic [SPEED_W-1:0] speed_count_out
);

	localparam int CHG_W = ERROR_WIDTH + 1;
	localparam int PE_W  = ERROR_WIDTH + GAIN_W;
	localparam int PD_W  = CHG_W + GAIN_W;
	localparam int BS_W  = GAIN_W + GAIN_FRAC_BITS;
	localparam int SW    = ((PD_W > BS_W) ? PD_W : BS_W) + 2;
	localparam int SHIFT = ERROR_WIDTH / 2 + GAIN_FRAC_BITS;

	logic signed [ERROR_WIDTH-1:0] err_h;
	logic signed [CHG_W-1:0]       change_h;
	logic                          fast_h;
	logic [SPEED_W-1:0]            speed_h;
	logic [GAIN_W-1:0]             kp_sel;
	logic [GAIN_W-1:0]             kd_sel;
	logic signed [PE_W-1:0]        prod_p_c;
	logic signed [PE_W-1:0]        prod_i_c;
	logic signed [PD_W-1:0]        prod_d_c;
	logic                          adv;

	logic                   valid_s1;
	logic signed [PE_W-1:0] prod_p_s1;
	logic signed [PE_W-1:0] prod_i_s1;
	logic signed [PD_W-1:0] prod_d_s1;
	logic [SPEED_W-1:0]     speed_s1;

	logic                 valid_s2;
	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] sum_s2;
	logic [SPEED_W-1:0]   speed_s2;

	logic signed [SW-1:0] rnd_c;
	logic signed [SW-1:0] quo_c;
	logic signed [SW-1:0] lim_c;
	logic signed [SW-1:0] sat_c;

	logic               out_valid_q;
	logic [DRIVE_W-1:0] drive_q;
	logic [SPEED_W-1:0] speed_q;

	assign {speed_h, fast_h, change_h, err_h} = entry;

	// The whole pipeline moves together whenever the output register can take a value.
	assign adv       = !out_valid_q || out_ready;
	assign entry_pop = adv && entry_valid;

	assign kp_sel   = fast_h ? cfg.kp_fast : cfg.kp_slow;
	assign kd_sel   = fast_h ? cfg.kd_fast : cfg.kd_slow;
	assign prod_p_c = err_h * $signed(kp_sel);
	assign prod_i_c = err_h * $signed(cfg.ki_gain);
	assign prod_d_c = change_h * $signed(kd_sel);

	assign sum_c = SW'(prod_p_s1) + SW'(prod_i_s1) + SW'(prod_d_s1)
		+ (SW'($signed(cfg.bias_term)) <<< GAIN_FRAC_BITS);

	// Adding the fraction mask to a negative sum makes the arithmetic shift round toward zero.
	assign rnd_c = sum_s2 + (sum_s2[SW-1] ? $signed({{(SW-SHIFT){1'b0}}, {SHIFT{1'b1}}})
		: $signed({SW{1'b0}}));
	assign quo_c = rnd_c >>> SHIFT;
	assign lim_c = $signed({{(SW-LIMIT_W){1'b0}}, cfg.out_limit});

	always_comb begin
		priority if (quo_c > lim_c) begin
			sat_c = lim_c;
		end else if (quo_c < -lim_c) begin
			sat_c = -lim_c;
		end else begin
			sat_c = quo_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= entry_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_p_s1 <= prod_p_c;
			prod_i_s1 <= prod_i_c;
			prod_d_s1 <= prod_d_c;
			speed_s1  <= speed_h;
			sum_s2    <= sum_c;
			speed_s2  <= speed_s1;
			drive_q   <= sat_c[DRIVE_W-1:0];
			speed_q   <= speed_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_value     = drive_q;
	assign speed_count_out = speed_q;

endmodule

@@ rtl/gain_scheduled_pd_controller.sv @@
// Throughput: one sample per cycle while the output is not stalled; the gain
// multipliers are registered once, the sum once, and the truncation and clamp
// feed the output register.
// A four-entry queue lets the input side keep accepting while the output stalls.
// Reset clears the previous error and change, zeroes all gains, sets the limit
// to 255 and empties the queue and pipeline.
module gain_scheduled_pd_controller
	import gspd_pkg::*;
#(
	parameter int ERROR_WIDTH    = DEF_ERROR_WIDTH,
	parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
	localparam int IN_W          = ((ERROR_WIDTH + SPEED_W + 7) / 8) * 8,
	localparam int OUT_W         = DRIVE_W + SPEED_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// error_sample, speed_count_in, zero fill
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// drive_value, speed_count_out
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ENT_W = 2 * ERROR_WIDTH + 10;

	gspd_cfg_t          cfg;
	logic               accept;
	logic [ENT_W-1:0]   entry_in;
	logic [ENT_W-1:0]   entry_out;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic [DRIVE_W-1:0] drive_value;
	logic [SPEED_W-1:0] speed_count_out;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	gspd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gspd_front #(
		.ERROR_WIDTH (ERROR_WIDTH),
		.ENT_W       (ENT_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.error_sample   (s_axis_tdata[ERROR_WIDTH-1:0]),
		.speed_count_in (s_axis_tdata[ERROR_WIDTH+SPEED_W-1:ERROR_WIDTH]),
		.cfg            (cfg),
		.entry          (entry_in)
	);

	gspd_fifo #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (entry_in),
		.pop    (q_pop),
		.rdata  (entry_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	gspd_back #(
		.ERROR_WIDTH    (ERROR_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.ENT_W          (ENT_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.entry           (entry_out),
		.entry_valid     (!q_empty),
		.entry_pop       (q_pop),
		.cfg             (cfg),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.drive_value     (drive_value),
		.speed_count_out (speed_count_out)
	);

	assign m_axis_tdata = {speed_count_out, drive_value};

endmodule

@@ rtl/gspd_checker.sv @@
// Port-level checks of the controller and their binding to the top level.
module gspd_checker
	import gspd_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [DRIVE_W+SPEED_W-1:0]   m_axis_tdata,
	input logic                         cfg_valid,
	input logic                         cfg_ready
);

	// A stalled result keeps its value until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The clamp is symmetric, so the most negative code never appears.
	a_drive_sym: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[DRIVE_W-1:0] != {1'b1, {(DRIVE_W-1){1'b0}}})
		else $error("drive outside the symmetric range");

	// Nothing is pending right after reset is released.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result present right after reset");

	// With the output idle the queue always has room for a new transaction.
	a_in_room: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && $past(!m_axis_tvalid, 1) && $past(!m_axis_tvalid, 2)
		&& $past(!m_axis_tvalid, 3) && $past(arst_n, 3) |-> s_axis_tready)
		else $error("input blocked although the output is idle");

	// Configuration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind gain_scheduled_pd_controller gspd_checker u_gspd_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the gain-scheduled PD controller stream and configuration ports.
module testbench
	import gspd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ERR_W       = DEF_ERROR_WIDTH;
	localparam int IN_W        = ((ERR_W + SPEED_W + 7) / 8) * 8;
	localparam int OUT_W       = DRIVE_W + SPEED_W;
	localparam int ERR_FRAC    = ERR_W / 2;
	localparam int GAIN_FRAC   = DEF_GAIN_FRAC_BITS;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 222;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic [SPEED_W-1:0]        speed;
	} drive_result_t;

	// Predicts the drive and speed count of each sample and checks them in order.
	class pd_drive_checker;
		logic signed [GAIN_W-1:0]   kp_fast, kd_fast, kp_slow, kd_slow, ki_gain, bias;
		logic signed [THRESH_W-1:0] threshold;
		logic [LIMIT_W-1:0]         limit;
		logic signed [ERR_W-1:0]    prev_error;
		logic signed [ERR_W:0]      prev_delta;
		drive_result_t              expected_drives[$];
		int                         fails;

		function new();
			kp_fast = '0; kd_fast = '0; kp_slow = '0; kd_slow = '0;
			ki_gain = '0; bias = '0; threshold = '0;
			limit = LIMIT_RESET;
			prev_error = '0;
			prev_delta = '0;
			fails = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_KP_FAST:   kp_fast = val[GAIN_W-1:0];
				REG_KD_FAST:   kd_fast = val[GAIN_W-1:0];
				REG_KP_SLOW:   kp_slow = val[GAIN_W-1:0];
				REG_KD_SLOW:   kd_slow = val[GAIN_W-1:0];
				REG_KI_GAIN:   ki_gain = val[GAIN_W-1:0];
				REG_BIAS:      bias = val[GAIN_W-1:0];
				REG_THRESHOLD: threshold = val[THRESH_W-1:0];
				REG_OUT_LIMIT: limit = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [ERR_W-1:0] err_bits, logic [SPEED_W-1:0] speed_in);
			longint err, chg, last_chg, kp, kd, sum, drv, lim;
			drive_result_t r;
			err = longint'($signed(err_bits));
			chg = err - longint'(prev_error);
			last_chg = longint'(prev_delta);
			if ((chg < 0 ? -chg : chg) < (last_chg < 0 ? -last_chg : last_chg))
				r.speed = speed_in + 8'd1;
			else
				r.speed = SPEED_RESTART;
			if (chg > longint'(threshold)) begin
				kp = longint'(kp_fast);
				kd = longint'(kd_fast);
			end else begin
				kp = longint'(kp_slow);
				kd = longint'(kd_slow);
			end
			sum = err * kp + longint'(bias) * (longint'(1) << GAIN_FRAC)
				+ err * longint'(ki_gain) + chg * kd;
			// Signed division truncates toward zero, as the block must.
			drv = sum / (longint'(1) << (ERR_FRAC + GAIN_FRAC));
			lim = longint'(limit);
			if (drv > lim)
				drv = lim;
			else if (drv < -lim)
				drv = -lim;
			r.drive = drv[DRIVE_W-1:0];
			prev_error = err_bits;
			prev_delta = chg[ERR_W:0];
			expected_drives.push_back(r);
		endfunction

		task report(string msg);
			if (fails < 40)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			fails++;
		endtask

		task check_drive(logic signed [DRIVE_W-1:0] drive, logic [SPEED_W-1:0] speed);
			drive_result_t e;
			if (expected_drives.size() == 0) begin
				report($sformatf("unexpected result drive=%0d speed=%0d", drive, speed));
			end else begin
				e = expected_drives.pop_front();
				if (drive !== e.drive)
					report($sformatf("drive_value %0d, expected %0d", drive, e.drive));
				if (speed !== e.speed)
					report($sformatf("speed_count_out %0d, expected %0d", speed, e.speed));
			end
		endtask

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// error_sample, speed_count_in
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// drive_value, speed_count_out
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pd_drive_checker sb = new();
	int              cycle_count = 0;
	int              tx_idle_pct = 0;
	int              rx_stall_pct = 0;
	bit              rx_hold = 0;
	logic [ERR_W-1:0] last_sent_error = '0;

	gain_scheduled_pd_controller u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// One process notes every transaction so that prediction and checking keep edge order.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_sample(s_axis_tdata[ERR_W-1:0], s_axis_tdata[ERR_W +: SPEED_W]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_drive(m_axis_tdata[DRIVE_W-1:0], m_axis_tdata[DRIVE_W +: SPEED_W]);
		end
	end

	always @(negedge clk) begin
		if (rx_hold)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	task automatic hold_receiver(input int cycles);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold = 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_sample(input logic [ERR_W-1:0] err, input logic [SPEED_W-1:0] speed);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {speed, err};
		last_sent_error = err;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'(int'($urandom_range(0, 8192)) - 4096);
			3: return 16'(int'($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [ERR_W-1:0] pick_error();
		case ($urandom_range(0, 6))
			0, 1: return 16'($urandom);
			2, 3: return last_sent_error + 16'(int'($urandom_range(0, 64)) - 32);
			4: return last_sent_error + 16'(int'($urandom_range(0, 4096)) - 2048);
			5: begin
				case ($urandom_range(0, 4))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
			default: return last_sent_error;
		endcase
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		return ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
	endfunction

	// Writes every register with random content; high bits beyond each width are random too.
	task automatic random_setting();
		logic [CFG_DATA_W-1:0] lim;
		cfg_reg_t r;
		r = r.first();
		repeat (REG_THRESHOLD) begin
			write_reg(r, {1'($urandom), pick_gain()});
			r = r.next();
		end
		case ($urandom_range(0, 3))
			0: write_reg(REG_THRESHOLD, 17'h10000);
			1: write_reg(REG_THRESHOLD, 17'h0FFFF);
			2: write_reg(REG_THRESHOLD, 17'(int'($urandom_range(0, 2000)) - 1000));
			default: write_reg(REG_THRESHOLD, 17'($urandom));
		endcase
		case ($urandom_range(0, 5))
			0: lim = '0;
			1: lim = 17'h07FFF;
			2: lim = 17'(LIMIT_RESET);
			default: lim = 17'($urandom_range(0, 32767));
		endcase
		lim[CFG_DATA_W-1:LIMIT_W] = 2'($urandom);
		write_reg(REG_OUT_LIMIT, lim);
		if ($urandom_range(0, 1))
			write_reg(8'($urandom_range(REG_OUT_LIMIT + 1, 255)), 17'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset gains are zero, so the drive stays at zero.
		send_sample(16'h7FFF, 8'h00);
		send_sample(16'h8000, 8'hFF);
		wait_drained();

		write_reg(REG_KP_FAST, 17'h07FFF);
		write_reg(REG_KD_FAST, 17'h08000);
		write_reg(REG_KP_SLOW, 17'h11000);
		write_reg(REG_KD_SLOW, 17'h00800);
		write_reg(REG_KI_GAIN, 17'h1F000);
		write_reg(REG_BIAS, 17'h07FFF);
		write_reg(REG_THRESHOLD, 17'h00000);
		write_reg(REG_OUT_LIMIT, 17'h1FFFF);
		// A write past the last register must change nothing.
		write_reg(8'(REG_OUT_LIMIT + 1), 17'h1FFFF);
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_sample(16'h0000, 8'd200);
		send_sample(16'h8000, 8'hFF);
		send_sample(16'h7FFF, 8'd7);
		send_sample(16'hFFFF, 8'hFF);
		send_sample(16'h0001, 8'd3);
		// Changes of +100 then -100: equal magnitudes restart the counter.
		send_sample(16'h0000, 8'd10);
		send_sample(16'd100, 8'd10);
		send_sample(16'h0000, 8'd10);
		// A shrinking change increments the counter, and 255 wraps to 0.
		send_sample(16'd100, 8'hFF);
		send_sample(16'd150, 8'hFF);
		send_sample(16'd170, 8'd254);
		wait_drained();

		// Zero limit forces a zero drive; lowest threshold always picks the fast pair.
		write_reg(REG_OUT_LIMIT, 17'h18000);
		write_reg(REG_THRESHOLD, 17'h10000);
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_sample(16'h7FFF, 8'd1);
		send_sample(16'h8000, 8'd2);
		send_sample(16'h1234, 8'd3);
		wait_drained();

		write_reg(REG_OUT_LIMIT, 17'(LIMIT_RESET));
		write_reg(REG_THRESHOLD, 17'h0FFFF);
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_sample(16'h8000, 8'd4);
		send_sample(16'h7FFF, 8'd5);
		send_sample(16'h0000, 8'd6);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			random_setting();
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
				default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
			endcase
			// The receiver goes quiet while samples keep coming, so the input side backs up.
			if (phase % 4 == 0 || phase == 2)
				fork
					hold_receiver(80);
				join_none
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && phase % 2 == 1)
					wait_drained();
				send_sample(pick_error(), pick_speed());
			end
			wait_drained();
		end

		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/gspd_pkg.sv
rtl/gspd_cfg.sv
rtl/gspd_front.sv
rtl/gspd_fifo.sv
rtl/gspd_back.sv
rtl/gain_scheduled_pd_controller.sv
rtl/gspd_checker.sv
dv/testbench.sv
